@@ hdl/palette_indexer_4bpp_top_assert.svh @@
// Assertion macros for the palette indexer, clocked on clk, reset by rst_n.
`ifndef PALETTE_INDEXER_4BPP_TOP_ASSERT_SVH
`define PALETTE_INDEXER_4BPP_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define PI4_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PI4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PI4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pi4_pkg.sv @@
package pi4_pkg;

  localparam int PALETTE_ENTRIES_DEF = 16;

  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int IDX_W  = 4;
  localparam int BYTE_W = 2 * IDX_W;
  localparam int C565_W = 16;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_DUMP  = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  localparam logic [C565_W-1:0] UNFILLED_565 = 16'hFFFF;

  function automatic logic [C565_W-1:0] to_565(input logic [RGB_W-1:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

@@ hdl/palette_indexer_4bpp_top.sv @@
// Palette indexer, 4 bits per pixel. Pixels (in_action = 0) are matched exactly against a
// palette that fills in order of first appearance; a new colour takes the next free slot and,
// with the palette full, an unmatched pixel gets index 0. Every second pixel yields one byte,
// first index in the high nibble. A dump (in_action = 1) drops any unpaired pixel and sends
// PALETTE_ENTRIES entries as RGB565, 0xFFFF for unfilled slots, last set on the final one.
// The palette sits in a single-port memory with a registered read, scanned one entry per
// cycle up to the first match or the last filled slot; a completed pair is handed over in
// ST_PAIR, and a dump reads each entry in ST_DUMP_RD and sends it in ST_DUMP_WR. Both
// handovers wait while out_ready is held low. in_ready is low while an item is in progress.
`include "palette_indexer_4bpp_top_assert.svh"

module palette_indexer_4bpp_top #(
  parameter int PALETTE_ENTRIES = pi4_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [pi4_pkg::CH_W-1:0]    in_red,
  input  logic [pi4_pkg::CH_W-1:0]    in_green,
  input  logic [pi4_pkg::CH_W-1:0]    in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [pi4_pkg::BYTE_W-1:0]  out_packed_byte,
  output logic [pi4_pkg::C565_W-1:0]  out_color565,
  output logic                        out_last
);

  import pi4_pkg::*;

  localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PALETTE_ENTRIES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PAIR,
    ST_DUMP_RD,
    ST_DUMP_WR
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_count_r, fill_count_nxt;
  logic [ADDR_W-1:0]   pending_index_r, pending_index_nxt;
  logic                have_pending_r, have_pending_nxt;
  logic [RGB_W-1:0]    rgb_r, rgb_nxt;
  logic [CNT_W-1:0]    addr_r, addr_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0]   cmp_addr_r, cmp_addr_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0]   out_packed_byte_r, out_packed_byte_nxt;
  logic [C565_W-1:0]   out_color565_r, out_color565_nxt;
  logic                out_last_r, out_last_nxt;

  logic [RGB_W-1:0]    palette_mem [PALETTE_ENTRIES];
  logic [RGB_W-1:0]    rd_data_r;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;

  logic                out_free;
  logic                match;
  logic [ADDR_W-1:0]   found_idx;
  logic                resolve;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_packed_byte = out_packed_byte_r;
  assign out_color565    = out_color565_r;
  assign out_last        = out_last_r;

  assign out_free = !out_valid_r || out_ready;
  assign match    = cmp_vld_r && (rd_data_r == rgb_r);

  always_comb begin
    state_nxt           = state_r;
    fill_count_nxt      = fill_count_r;
    pending_index_nxt   = pending_index_r;
    have_pending_nxt    = have_pending_r;
    rgb_nxt             = rgb_r;
    addr_nxt            = addr_r;
    cmp_vld_nxt         = cmp_vld_r;
    cmp_addr_nxt        = cmp_addr_r;
    idx_nxt             = idx_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_kind_nxt        = out_kind_r;
    out_packed_byte_nxt = out_packed_byte_r;
    out_color565_nxt    = out_color565_r;
    out_last_nxt        = out_last_r;
    mem_re              = 1'b0;
    mem_raddr           = addr_r[ADDR_W-1:0];
    mem_we              = 1'b0;
    mem_waddr           = fill_count_r[ADDR_W-1:0];
    found_idx           = '0;
    resolve             = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          addr_nxt    = '0;
          cmp_vld_nxt = 1'b0;
          if (in_action == ACTION_DUMP) begin
            have_pending_nxt  = 1'b0;
            pending_index_nxt = '0;
            state_nxt         = ST_DUMP_RD;
          end else begin
            rgb_nxt   = {in_red, in_green, in_blue};
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          found_idx = cmp_addr_r;
          resolve   = 1'b1;
        end else if (addr_r < fill_count_r) begin
          mem_re       = 1'b1;
          cmp_addr_nxt = addr_r[ADDR_W-1:0];
          cmp_vld_nxt  = 1'b1;
          addr_nxt     = addr_r + CNT_W'(1);
        end else begin
          resolve = 1'b1;
          if (fill_count_r < FULL_CNT) begin
            mem_we         = 1'b1;
            found_idx      = fill_count_r[ADDR_W-1:0];
            fill_count_nxt = fill_count_r + CNT_W'(1);
          end
        end
        if (resolve) begin
          cmp_vld_nxt = 1'b0;
          if (have_pending_r) begin
            idx_nxt   = found_idx;
            state_nxt = ST_PAIR;
          end else begin
            pending_index_nxt = found_idx;
            have_pending_nxt  = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end
      end
      ST_PAIR: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_kind_nxt        = KIND_BYTE;
          out_packed_byte_nxt = {IDX_W'(pending_index_r), IDX_W'(idx_r)};
          out_color565_nxt    = '0;
          out_last_nxt        = 1'b1;
          have_pending_nxt    = 1'b0;
          pending_index_nxt   = '0;
          state_nxt           = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_DUMP_WR;
      end
      ST_DUMP_WR: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_kind_nxt        = KIND_ENTRY;
          out_packed_byte_nxt = '0;
          out_color565_nxt    = (addr_r < fill_count_r) ? to_565(rd_data_r) : UNFILLED_565;
          out_last_nxt        = (addr_r == LAST_CNT);
          if (addr_r == LAST_CNT) begin
            state_nxt = ST_IDLE;
          end else begin
            addr_nxt  = addr_r + CNT_W'(1);
            state_nxt = ST_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= rgb_r;
    end
    if (mem_re) begin
      rd_data_r <= palette_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      fill_count_r    <= '0;
      pending_index_r <= '0;
      have_pending_r  <= 1'b0;
      cmp_vld_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      fill_count_r    <= fill_count_nxt;
      pending_index_r <= pending_index_nxt;
      have_pending_r  <= have_pending_nxt;
      cmp_vld_r       <= cmp_vld_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    rgb_r             <= rgb_nxt;
    addr_r            <= addr_nxt;
    cmp_addr_r        <= cmp_addr_nxt;
    idx_r             <= idx_nxt;
    out_kind_r        <= out_kind_nxt;
    out_packed_byte_r <= out_packed_byte_nxt;
    out_color565_r    <= out_color565_nxt;
    out_last_r        <= out_last_nxt;
  end

  `PI4_ASSERT_ALWAYS(a_fill_bounded, fill_count_r <= FULL_CNT, "fill count beyond palette size")
  `PI4_ASSERT_SAME(a_fill_step, $past(rst_n), (fill_count_r == $past(fill_count_r)) || (fill_count_r == $past(fill_count_r) + CNT_W'(1)), "fill count moved by more than one")
  `PI4_ASSERT_NEXT(a_dump_drops_pending, in_valid && in_ready && (in_action == ACTION_DUMP), !have_pending_r, "pending half pair kept across dump")
  `PI4_ASSERT_SAME(a_byte_is_last, out_valid_r && (out_kind_r == KIND_BYTE), out_last_r && (out_color565_r == '0), "byte item without last or with colour")

endmodule
